@@ sv/lcf_pkg.sv @@
// Shared constants, types and pair arithmetic for the LIS length/count core.
`default_nettype none

package lcf_pkg;

  localparam int unsigned MaxValue  = 1024;
  localparam int unsigned StoreSize = MaxValue + 2;
  localparam int unsigned AddrW     = $clog2(StoreSize);
  localparam int unsigned WalkW     = AddrW + 1;
  localparam int unsigned ValW      = 11;
  localparam int unsigned LenW      = 11;
  localparam int unsigned CntW      = 60;

  localparam logic [ValW-1:0] CfgReset = ValW'(MaxValue);
  localparam logic [LenW-1:0] LenMax   = '1;
  localparam logic [CntW-1:0] CountCap = 60'd1000000000000000000;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [CntW-1:0] cnt;
  } pair_t;

  typedef enum logic [1:0] {
    WalkSeed,
    WalkRun,
    WalkMerge,
    WalkBest
  } lcf_walk_e;

  typedef struct packed {
    logic      load;
    logic      clr_start;
    logic      walk_start;
    lcf_walk_e walk_kind;
    logic      out_load;
  } lcf_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic walk_done;
    logic first;
    logic bad;
    logic out_free;
  } lcf_sts_t;

  // larger length wins; equal lengths add counts, saturating
  function automatic pair_t pair_join(pair_t a, pair_t b);
    logic [CntW:0] sum;
    pair_t         r;
    r   = a;
    sum = {1'b0, a.cnt} + {1'b0, b.cnt};
    if (a.len < b.len) begin
      r = b;
    end else if (a.len == b.len) begin
      r.cnt = (sum > {1'b0, CountCap}) ? CountCap : sum[CntW-1:0];
    end
    return r;
  endfunction

  function automatic pair_t pair_extend(pair_t a);
    pair_t r;
    r = a;
    if (a.len < LenMax) begin
      r.len = a.len + LenW'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/lcf_in_if.sv @@
// Input channel: one sequence value per beat.
`default_nettype none

interface lcf_in_if import lcf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ValW-1:0] value;
  logic            first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

`default_nettype wire

@@ sv/lcf_out_if.sv @@
// Output channel: one result pair and running best per beat.
`default_nettype none

interface lcf_out_if import lcf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LenW-1:0] run_length;
  logic [CntW-1:0] run_count;
  logic [LenW-1:0] best_length;
  logic [CntW-1:0] best_count;
  logic            bad_value;

  modport source (output valid, output run_length, output run_count, output best_length,
                  output best_count, output bad_value, input ready);
  modport sink   (input valid, input run_length, input run_count, input best_length,
                  input best_count, input bad_value, output ready);
endinterface

`default_nettype wire

@@ sv/lcf_datapath.sv @@
// Datapath: tree store, clear sweep, tree walk engine and output register.
`default_nettype none

module lcf_datapath import lcf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [ValW-1:0] cfg_wdata_i,
  input  wire logic [ValW-1:0] in_value_i,
  input  wire logic            in_first_i,
  input  wire lcf_cmd_t        cmd_i,
  output lcf_sts_t             sts_o,
  lcf_out_if.source            out_o
);

  function automatic logic [ValW-1:0] bound(logic [ValW-1:0] vc);
    logic [ValW-1:0] n;
    n = vc;
    if (vc == '0) begin
      n = ValW'(1);
    end else if (vc > ValW'(MaxValue)) begin
      n = ValW'(MaxValue);
    end
    return n;
  endfunction

  pair_t store_q [StoreSize];
  pair_t rd_q;

  logic [ValW-1:0]  value_count_q;
  logic [ValW-1:0]  v_q, n_q;
  logic             first_q, bad_q;
  logic [ValW-1:0]  n_cur;

  logic             clr_act_q;
  logic [AddrW-1:0] clr_addr_q;

  logic             act_q, up_q, pend_q;
  logic [WalkW-1:0] x_q, x_d;
  logic [AddrW-1:0] pend_addr_q;
  pair_t            acc_q, run_q, d_q;

  logic             out_vld_q;
  pair_t            out_run_q, out_best_q;
  logic             out_bad_q;

  logic [WalkW-1:0] top, lsb;
  logic             issue;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  pair_t            wr_data;

  assign n_cur = bound(value_count_q);
  assign top   = WalkW'(n_q) + WalkW'(1);
  assign lsb   = x_q & (~x_q + WalkW'(1));
  assign issue = act_q && (x_q != '0) && (!up_q || (x_q <= top));
  assign x_d   = up_q ? (x_q + lsb) : (x_q - lsb);

  assign wr_en   = clr_act_q || (pend_q && !up_q);
  assign wr_addr = clr_act_q ? clr_addr_q : pend_addr_q;
  assign wr_data = clr_act_q ? pair_t'('0) : pair_join(rd_q, d_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_q <= store_q[x_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_count_q <= CfgReset;
    end else if (cfg_we_i) begin
      value_count_q <= cfg_wdata_i;
    end
  end

  // item registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
      bad_q   <= 1'b0;
      v_q     <= '0;
      n_q     <= '0;
    end else if (cmd_i.load) begin
      v_q     <= in_value_i;
      first_q <= in_first_i;
      n_q     <= n_cur;
      bad_q   <= (in_value_i == '0) || (in_value_i > n_cur);
    end
  end

  // clear sweep, also run out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q  <= 1'b1;
      clr_addr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_act_q  <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_act_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(StoreSize - 1)) begin
        clr_act_q <= 1'b0;
      end
    end
  end

  // walk engine: one read per cycle, join or write-back in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      up_q        <= 1'b0;
      pend_q      <= 1'b0;
      x_q         <= '0;
      pend_addr_q <= '0;
      acc_q       <= '0;
      run_q       <= '0;
      d_q         <= '0;
    end else begin
      if (cmd_i.load) begin
        run_q <= '0;
      end
      if (pend_q && up_q) begin
        acc_q <= pair_join(rd_q, acc_q);
      end
      pend_q      <= issue;
      pend_addr_q <= x_q[AddrW-1:0];
      if (cmd_i.walk_start) begin
        act_q  <= 1'b1;
        pend_q <= 1'b0;
        case (cmd_i.walk_kind)
          WalkSeed: begin
            up_q  <= 1'b0;
            x_q   <= WalkW'(n_q) + WalkW'(1);
            d_q   <= '{len: '0, cnt: CntW'(1)};
          end
          WalkRun: begin
            up_q  <= 1'b1;
            x_q   <= WalkW'(v_q) + WalkW'(1);
            acc_q <= '0;
          end
          WalkMerge: begin
            up_q  <= 1'b0;
            x_q   <= WalkW'(v_q);
            d_q   <= pair_extend(acc_q);
            run_q <= pair_extend(acc_q);
          end
          default: begin
            up_q  <= 1'b1;
            x_q   <= WalkW'(1);
            acc_q <= '0;
          end
        endcase
      end else if (issue) begin
        x_q <= x_d;
      end else begin
        act_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_run_q  <= run_q;
      out_best_q <= acc_q;
      out_bad_q  <= bad_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.run_length  = out_run_q.len;
  assign out_o.run_count   = out_run_q.cnt;
  assign out_o.best_length = out_best_q.len;
  assign out_o.best_count  = out_best_q.cnt;
  assign out_o.bad_value   = out_bad_q;

  assign sts_o.clr_done  = !clr_act_q;
  assign sts_o.walk_done = !act_q && !pend_q;
  assign sts_o.first     = first_q;
  assign sts_o.bad       = bad_q;
  assign sts_o.out_free  = !out_vld_q || out_o.ready;

  a_clr_walk_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_act_q && (act_q || pend_q)))
    else $error("clear sweep overlaps a walk");

  a_acc_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q.cnt <= CountCap)
    else $error("accumulated count above cap");

  a_rw_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && wr_en) |-> (wr_addr != x_q[AddrW-1:0]))
    else $error("read and write hit the same entry");

endmodule

`default_nettype wire

@@ sv/lcf_ctrl.sv @@
// Controller: sequences clear, seed, query, merge and best walks per item.
`default_nettype none

module lcf_ctrl import lcf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire lcf_sts_t sts_i,
  output lcf_cmd_t      cmd_o
);

  localparam logic [3:0] StInit  = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StStart = 4'd2;
  localparam logic [3:0] StClear = 4'd3;
  localparam logic [3:0] StSeed  = 4'd4;
  localparam logic [3:0] StQuery = 4'd5;
  localparam logic [3:0] StMerge = 4'd6;
  localparam logic [3:0] StBest  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.walk_kind  = WalkBest;
    unique case (state_q)
      StInit: begin
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StStart;
        end
      end
      StStart: begin
        if (sts_i.first) begin
          cmd_o.clr_start = 1'b1;
          state_d         = StClear;
        end else if (!sts_i.bad) begin
          cmd_o.walk_start = 1'b1;
          cmd_o.walk_kind  = WalkRun;
          state_d          = StQuery;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = StBest;
        end
      end
      StClear: begin
        if (sts_i.clr_done) begin
          cmd_o.walk_start = 1'b1;
          cmd_o.walk_kind  = WalkSeed;
          state_d          = StSeed;
        end
      end
      StSeed: begin
        if (sts_i.walk_done) begin
          cmd_o.walk_start = 1'b1;
          if (sts_i.bad) begin
            state_d = StBest;
          end else begin
            cmd_o.walk_kind = WalkRun;
            state_d         = StQuery;
          end
        end
      end
      StQuery: begin
        if (sts_i.walk_done) begin
          cmd_o.walk_start = 1'b1;
          cmd_o.walk_kind  = WalkMerge;
          state_d          = StMerge;
        end
      end
      StMerge: begin
        if (sts_i.walk_done) begin
          cmd_o.walk_start = 1'b1;
          state_d          = StBest;
        end
      end
      StBest: begin
        if (sts_i.walk_done) state_d = StOut;
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk_start |=> !sts_i.walk_done)
    else $error("walk did not start");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StStart))
    else $error("item loaded outside idle");

  a_ready_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (sts_i.walk_done && sts_i.clr_done))
    else $error("input ready while datapath busy");

endmodule

`default_nettype wire

@@ sv/lis_length_count_fenwick_core.sv @@
// Top level: LIS length and count over a suffix Fenwick tree store.
//
//   port         dir   beat contents
//   in_i         sink  value, first
//   out_o        src   run_length, run_count, best_length, best_count, bad_value
//   cfg_we_i     in    value_count write (cfg_wdata_i)
//
// Per item: load, then the query, merge and full-range walks, each touching
// at most 11 nodes, then the output load; an out-of-range value skips
// the query and merge walks.
// Items with first set add a store clear over all 1026 entries plus a seed walk.
// After reset all 1026 store entries are cleared before in_i.ready rises.
// A result waits in the output register; the next item is taken meanwhile.
// One memory read and one write port set the walk speed: one node per cycle.
`default_nettype none

module lis_length_count_fenwick_core import lcf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [ValW-1:0] cfg_wdata_i,
  lcf_in_if.sink               in_i,
  lcf_out_if.source            out_o
);

  lcf_cmd_t cmd;
  lcf_sts_t sts;

  lcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_value_i  (in_i.value),
    .in_first_i  (in_i.first),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
